// ===== design/pid_with_error_and_output_clamp_assert.svh =====
// Assertion macros used by the PID controller top level.
`ifndef PID_WITH_ERROR_AND_OUTPUT_CLAMP_ASSERT_SVH
`define PID_WITH_ERROR_AND_OUTPUT_CLAMP_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define PIDC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pidc assertion failed");

// next-cycle implication, sampled on aclk, off during reset
`define PIDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pidc assertion failed");

`endif

// ===== design/pidc_pkg.sv =====
package pidc_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 12;
    localparam int INTEGRAL_WIDTH_DEF = 24;

    localparam int GAIN_W      = 18;
    localparam int ELIM_W      = 11;
    localparam int OUT_W       = 16;
    localparam int CFG_DATA_W  = 18;
    localparam int CFG_IDX_W   = 3;
    localparam int ROUND_SHIFT = 8;

    localparam logic [GAIN_W-1:0]       KP_RESET       = 18'd1114;
    localparam logic [GAIN_W-1:0]       KI_RESET       = 18'd983;
    localparam logic [GAIN_W-1:0]       KD_RESET       = 18'd131;
    localparam logic [ELIM_W-1:0]       ERR_LIM_RESET  = 11'd300;
    localparam logic signed [OUT_W-1:0] OUT_MAX_RESET  = 16'sd20480;
    localparam logic signed [OUT_W-1:0] OUT_MIN_RESET  = -16'sd15360;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT    = 3'd0,
        REG_KP_GAIN     = 3'd1,
        REG_KI_GAIN     = 3'd2,
        REG_KD_GAIN     = 3'd3,
        REG_ERROR_LIMIT = 3'd4,
        REG_OUTPUT_MAX  = 3'd5,
        REG_OUTPUT_MIN  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0]       kp_gain;
        logic [GAIN_W-1:0]       ki_gain;
        logic [GAIN_W-1:0]       kd_gain;
        logic [ELIM_W-1:0]       error_limit;
        logic signed [OUT_W-1:0] output_max;
        logic signed [OUT_W-1:0] output_min;
    } pidc_cfg_t;

endpackage

// ===== design/pidc_err.sv =====
module pidc_err import pidc_pkg::*; #(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]   in_meas,
    input  logic                             in_clear,
    input  logic signed [SAMPLE_WIDTH-1:0]   setpoint,
    input  pidc_cfg_t                        cfg,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]   out_err,
    output logic signed [INTEGRAL_WIDTH-1:0] out_acc,
    output logic signed [SAMPLE_WIDTH:0]     out_derr
);

    localparam int DW = (SAMPLE_WIDTH > ELIM_W) ? SAMPLE_WIDTH + 2 : ELIM_W + 2;
    localparam int SW = SAMPLE_WIDTH;
    localparam int IW = INTEGRAL_WIDTH;
    localparam logic signed [DW-1:0]   SMAX = DW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [DW-1:0]   SMIN = -SMAX - DW'(1);
    localparam logic signed [IW:0]     IMAX = (IW + 1)'((64'sd1 <<< (IW - 1)) - 64'sd1);
    localparam logic signed [IW:0]     IMIN = -IMAX - (IW + 1)'(1);

    logic                 valid_reg;
    logic signed [IW-1:0] sum_reg;
    logic signed [SW-1:0] prev_reg;
    logic signed [SW-1:0] err_reg;
    logic signed [IW-1:0] acc_reg;
    logic signed [SW:0]   derr_reg;

    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] lim_pos;
    logic signed [DW-1:0] lim_neg;
    logic signed [DW-1:0] e_lim;
    logic signed [DW-1:0] e_sat;
    logic signed [SW-1:0] err_next;
    logic signed [IW-1:0] base;
    logic signed [IW:0]   acc_wide;
    logic signed [IW-1:0] acc_next;
    logic signed [SW:0]   derr_next;
    logic                 fire;

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    assign diff    = DW'(setpoint) - DW'(in_meas);
    assign lim_pos = $signed(DW'(cfg.error_limit));
    assign lim_neg = -lim_pos;

    always_comb begin
        if (diff > lim_pos) begin
            e_lim = lim_pos;
        end else if (diff < lim_neg) begin
            e_lim = lim_neg;
        end else begin
            e_lim = diff;
        end
        if (e_lim > SMAX) begin
            e_sat = SMAX;
        end else if (e_lim < SMIN) begin
            e_sat = SMIN;
        end else begin
            e_sat = e_lim;
        end
        err_next = e_sat[SW-1:0];

        base     = in_clear ? '0 : sum_reg;
        acc_wide = (IW + 1)'(base) + (IW + 1)'(err_next);
        if (acc_wide > IMAX) begin
            acc_next = IMAX[IW-1:0];
        end else if (acc_wide < IMIN) begin
            acc_next = IMIN[IW-1:0];
        end else begin
            acc_next = acc_wide[IW-1:0];
        end

        derr_next = (SW + 1)'(err_next) - (SW + 1)'(prev_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sum_reg   <= '0;
            prev_reg  <= '0;
        end else if (fire) begin
            valid_reg <= 1'b1;
            sum_reg   <= acc_next;
            prev_reg  <= err_next;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            err_reg  <= err_next;
            acc_reg  <= acc_next;
            derr_reg <= derr_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_err   = err_reg;
    assign out_acc   = acc_reg;
    assign out_derr  = derr_reg;

endmodule

// ===== design/pidc_mix.sv =====
module pidc_mix import pidc_pkg::*; #(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]   in_err,
    input  logic signed [INTEGRAL_WIDTH-1:0] in_acc,
    input  logic signed [SAMPLE_WIDTH:0]     in_derr,
    input  pidc_cfg_t                        cfg,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [OUT_W-1:0]          out_drive,
    output logic                             out_clamped
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int IW    = INTEGRAL_WIDTH;
    localparam int PI_W  = GAIN_W + IW + 1;
    localparam int PD_W  = GAIN_W + SW + 2;
    localparam int PP_W  = GAIN_W + SW + 1;
    localparam int SUM_W = ((PI_W > PD_W) ? PI_W : PD_W) + 2;
    localparam int V_W   = SUM_W - ROUND_SHIFT;
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1 << (ROUND_SHIFT - 1));

    logic                    valid_reg;
    logic signed [OUT_W-1:0] drive_reg;
    logic                    clamped_reg;

    logic signed [PP_W-1:0]  p_kp;
    logic signed [PI_W-1:0]  p_ki;
    logic signed [PD_W-1:0]  p_kd;
    logic signed [SUM_W-1:0] sum;
    logic signed [V_W-1:0]   v;
    logic signed [V_W-1:0]   hi;
    logic signed [V_W-1:0]   lo;
    logic signed [OUT_W-1:0] drive_next;
    logic                    clamped_next;
    logic                    fire;

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    assign p_kp = $signed({1'b0, cfg.kp_gain}) * in_err;
    assign p_ki = $signed({1'b0, cfg.ki_gain}) * in_acc;
    assign p_kd = $signed({1'b0, cfg.kd_gain}) * in_derr;
    assign sum  = SUM_W'(p_kp) + SUM_W'(p_ki) + SUM_W'(p_kd) + ROUND_BIAS;
    assign v    = sum[SUM_W-1:ROUND_SHIFT];
    assign hi   = V_W'(cfg.output_max);
    assign lo   = V_W'(cfg.output_min);

    always_comb begin
        if (v > hi) begin
            drive_next   = cfg.output_max;
            clamped_next = 1'b1;
        end else if (v < lo) begin
            drive_next   = cfg.output_min;
            clamped_next = 1'b1;
        end else begin
            drive_next   = v[OUT_W-1:0];
            clamped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (fire) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            drive_reg   <= drive_next;
            clamped_reg <= clamped_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_drive   = drive_reg;
    assign out_clamped = clamped_reg;

endmodule

// ===== design/pid_with_error_and_output_clamp.sv =====
// An input transfer reaches its result through the input, error and output registers.
// Throughput: one sample per cycle unless stalled; integral and last error update per sample.
// Each stage holds while the next one is full and stalled; the input side stays ready otherwise.
// Reset (aresetn low, synchronous): pipeline emptied, integral and last error zeroed,
// configuration registers back to their defaults.
`include "pid_with_error_and_output_clamp_assert.svh"

module pid_with_error_and_output_clamp import pidc_pkg::*; #(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,  // measurement
    input  logic [0:0]                             s_tuser,  // clear_integral
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [OUT_W-1:0]                       m_tdata,  // drive
    output logic [0:0]                             m_tuser,  // output_clamped
    input  logic                                   cfg_wen,
    input  logic [CFG_IDX_W-1:0]                   cfg_index,
    input  logic [CFG_DATA_W-1:0]                  cfg_wdata
);

    logic signed [SAMPLE_WIDTH-1:0]   setpoint_reg;
    pidc_cfg_t                        cfg_reg;

    logic                             a_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]   a_meas_reg;
    logic                             a_clear_reg;

    logic                             b_in_ready;
    logic                             b_valid;
    logic                             b_ready;
    logic signed [SAMPLE_WIDTH-1:0]   b_err;
    logic signed [INTEGRAL_WIDTH-1:0] b_acc;
    logic signed [SAMPLE_WIDTH:0]     b_derr;
    logic signed [OUT_W-1:0]          drive;
    logic                             clamped;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg        <= '0;
            cfg_reg.kp_gain     <= KP_RESET;
            cfg_reg.ki_gain     <= KI_RESET;
            cfg_reg.kd_gain     <= KD_RESET;
            cfg_reg.error_limit <= ERR_LIM_RESET;
            cfg_reg.output_max  <= OUT_MAX_RESET;
            cfg_reg.output_min  <= OUT_MIN_RESET;
        end else if (cfg_wen) begin
            case (cfg_index_t'(cfg_index))
                REG_SETPOINT:    setpoint_reg        <= cfg_wdata[SAMPLE_WIDTH-1:0];
                REG_KP_GAIN:     cfg_reg.kp_gain     <= cfg_wdata[GAIN_W-1:0];
                REG_KI_GAIN:     cfg_reg.ki_gain     <= cfg_wdata[GAIN_W-1:0];
                REG_KD_GAIN:     cfg_reg.kd_gain     <= cfg_wdata[GAIN_W-1:0];
                REG_ERROR_LIMIT: cfg_reg.error_limit <= cfg_wdata[ELIM_W-1:0];
                REG_OUTPUT_MAX:  cfg_reg.output_max  <= cfg_wdata[OUT_W-1:0];
                REG_OUTPUT_MIN:  cfg_reg.output_min  <= cfg_wdata[OUT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register: hold while the error stage is stalled
    assign s_tready = !a_valid_reg || b_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            a_valid_reg <= 1'b1;
        end else if (b_in_ready) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_meas_reg  <= s_tdata[SAMPLE_WIDTH-1:0];
            a_clear_reg <= s_tuser[0];
        end
    end

    pidc_err #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_err (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid_reg),
        .in_ready  (b_in_ready),
        .in_meas   (a_meas_reg),
        .in_clear  (a_clear_reg),
        .setpoint  (setpoint_reg),
        .cfg       (cfg_reg),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_err   (b_err),
        .out_acc   (b_acc),
        .out_derr  (b_derr)
    );

    pidc_mix #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_mix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (b_valid),
        .in_ready    (b_ready),
        .in_err      (b_err),
        .in_acc      (b_acc),
        .in_derr     (b_derr),
        .cfg         (cfg_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_drive   (drive),
        .out_clamped (clamped)
    );

    assign m_tdata    = drive;
    assign m_tuser[0] = clamped;

    `PIDC_ASSERT_NOW(a_stall_blocks_input, a_valid_reg && !b_in_ready, !s_tready)
    `PIDC_ASSERT_NEXT(b_stall_holds, b_valid && !b_ready, b_valid)
    `PIDC_ASSERT_NEXT(out_drains_empty, m_tvalid && m_tready && !b_valid, !m_tvalid)

endmodule
